FILE: sv/vector_to_vector_rotation_macros.svh
// Assertion helpers shared by the rotation block.
`ifndef VECTOR_TO_VECTOR_ROTATION_MACROS_SVH
`define VECTOR_TO_VECTOR_ROTATION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define VVR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector_to_vector_rotation assertion failed");
// Next-cycle implication, disabled while reset is held.
`define VVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector_to_vector_rotation assertion failed");
`else
`define VVR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define VVR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/vvr_pkg.sv
package vvr_pkg;

    // Component format.
    localparam int CW = 16;
    localparam int FB = 14;

    // Intermediate widths.
    localparam int PROD_W  = 2 * CW;
    localparam int CROSS_W = 2 * CW + 1;
    localparam int E_W     = 2 * CW + 2;
    localparam int Q_W     = CROSS_W - FB;
    localparam int QMAG_W  = Q_W - 1;
    localparam int PMAG_W  = 2 * QMAG_W - 1;
    localparam int VV_W    = 2 * QMAG_W;
    localparam int NUM_W   = PMAG_W + 2 * FB;
    localparam int QUO_W   = 2 * FB + 1;
    localparam int R_W     = QUO_W + 1;
    localparam int M_W     = E_W + R_W;
    localparam int OUT_SH  = 3 * FB;
    localparam int CFG_W   = 31;

    localparam int NAX  = 3;
    localparam int NRAT = 6;

    // Ratio slots: squares first, then the cross terms.
    localparam int RAT_XX = 0;
    localparam int RAT_YY = 1;
    localparam int RAT_ZZ = 2;
    localparam int RAT_XY = 3;
    localparam int RAT_XZ = 4;
    localparam int RAT_YZ = 5;

    // Axis slots.
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    localparam logic signed [E_W-1:0] UNIT2 = E_W'(1) << (2 * FB);
    localparam logic [CFG_W-1:0] MIN_CROSS_RESET = CFG_W'(1);

    typedef struct packed {
        logic signed [CW-1:0] source_x;
        logic signed [CW-1:0] source_y;
        logic signed [CW-1:0] source_z;
        logic signed [CW-1:0] target_x;
        logic signed [CW-1:0] target_y;
        logic signed [CW-1:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] rot_00;
        logic signed [CW-1:0] rot_01;
        logic signed [CW-1:0] rot_02;
        logic signed [CW-1:0] rot_10;
        logic signed [CW-1:0] rot_11;
        logic signed [CW-1:0] rot_12;
        logic signed [CW-1:0] rot_20;
        logic signed [CW-1:0] rot_21;
        logic signed [CW-1:0] rot_22;
        logic                 identity_used;
    } t_out_item;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [NRAT-1:0][NUM_W-1:0] num;
        logic [NRAT-1:0]            neg;
        logic [VV_W-1:0]            vv;
        logic signed [E_W-1:0]      e2;
        logic signed [E_W-1:0]      om;
        logic [NAX-1:0][Q_W-1:0]    q;
        logic                       ident;
    } t_mid_item;

    // Data that rides beside the dividers.
    typedef struct packed {
        logic [NRAT-1:0]         neg;
        logic signed [E_W-1:0]   e2;
        logic signed [E_W-1:0]   om;
        logic [NAX-1:0][Q_W-1:0] q;
        logic                    ident;
    } t_side;

    // Handshake between the middle queue and the back.
    typedef struct packed {
        logic valid;
        logic pop;
    } t_mq_ctl;

endpackage

FILE: sv/vvr_front.sv
module vvr_front
    import vvr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  t_in_item         i_item,
    input  logic [CFG_W-1:0] i_min_cross_sq,
    input  logic             i_mq_pop,
    output logic             o_mq_valid,
    output t_mid_item        o_mq_item
);

    localparam logic [1:0] MQ_FULL = 2'd2;
    localparam logic signed [CROSS_W:0] RND_Q = (CROSS_W + 1)'(1) << (FB - 1);

    logic fen;
    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [PROD_W-1:0]  r_p [9];
    logic signed [E_W-1:0]     r_e2_2, r_e2_3, r_e2_4, r_om4;
    logic signed [Q_W-1:0]     r_q2 [NAX];
    logic signed [Q_W-1:0]     r_q3 [NAX];
    logic signed [Q_W-1:0]     r_q4 [NAX];
    logic signed [2*Q_W-1:0]   r_sq [NRAT];
    logic [PMAG_W-1:0]         r_mag4 [NRAT];
    logic [NRAT-1:0]           r_neg4;
    logic [VV_W-1:0]           r_vv4;
    logic                      r_id4;

    logic signed [CROSS_W-1:0] cross_v [NAX];
    logic signed [CROSS_W:0]   cross_rnd [NAX];
    logic signed [E_W-1:0]     n_e2;
    logic [VV_W-1:0]           n_vv;
    logic                      n_id;
    logic [NRAT-1:0]           n_neg;
    logic [PMAG_W-1:0]         n_mag [NRAT];
    t_mid_item                 mid;

    t_mid_item  r_mq [2];
    logic       r_mq_wp, r_mq_rp;
    logic [1:0] r_mq_cnt, n_mq_cnt;
    logic       mq_push;

    // The whole front advances together while the middle queue has room.
    assign fen    = (r_mq_cnt != MQ_FULL);
    assign o_full = !fen;

    // Valid bits of the four front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (fen) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage one: the nine component products.
    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_p[0] <= i_item.source_x * i_item.target_x;
            r_p[1] <= i_item.source_y * i_item.target_y;
            r_p[2] <= i_item.source_z * i_item.target_z;
            r_p[3] <= i_item.source_y * i_item.target_z;
            r_p[4] <= i_item.source_z * i_item.target_y;
            r_p[5] <= i_item.source_z * i_item.target_x;
            r_p[6] <= i_item.source_x * i_item.target_z;
            r_p[7] <= i_item.source_x * i_item.target_y;
            r_p[8] <= i_item.source_y * i_item.target_x;
        end
    end

    // Stage two: dot product and rounded cross product.
    always_comb begin
        n_e2 = E_W'(r_p[0]) + E_W'(r_p[1]) + E_W'(r_p[2]);
        cross_v[AX_X] = CROSS_W'(r_p[3]) - CROSS_W'(r_p[4]);
        cross_v[AX_Y] = CROSS_W'(r_p[5]) - CROSS_W'(r_p[6]);
        cross_v[AX_Z] = CROSS_W'(r_p[7]) - CROSS_W'(r_p[8]);
        for (int k = 0; k < NAX; k++) begin
            cross_rnd[k] = (CROSS_W + 1)'(cross_v[k]) + RND_Q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_e2_2 <= n_e2;
            for (int k = 0; k < NAX; k++) begin
                r_q2[k] <= Q_W'(cross_rnd[k] >>> FB);
            end
        end
    end

    // Stage three: squares and cross terms of the rounded cross product.
    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_sq[RAT_XX] <= r_q2[AX_X] * r_q2[AX_X];
            r_sq[RAT_YY] <= r_q2[AX_Y] * r_q2[AX_Y];
            r_sq[RAT_ZZ] <= r_q2[AX_Z] * r_q2[AX_Z];
            r_sq[RAT_XY] <= r_q2[AX_X] * r_q2[AX_Y];
            r_sq[RAT_XZ] <= r_q2[AX_X] * r_q2[AX_Z];
            r_sq[RAT_YZ] <= r_q2[AX_Y] * r_q2[AX_Z];
            r_e2_3 <= r_e2_2;
            r_q3   <= r_q2;
        end
    end

    // Stage four: squared length, threshold test and magnitudes.
    always_comb begin
        n_vv = VV_W'(r_sq[RAT_XX]) + VV_W'(r_sq[RAT_YY]) + VV_W'(r_sq[RAT_ZZ]);
        n_id = (n_vv == '0) || (n_vv < VV_W'(i_min_cross_sq));
        for (int k = 0; k < NRAT; k++) begin
            n_neg[k] = r_sq[k][2*Q_W-1];
            n_mag[k] = n_neg[k] ? PMAG_W'(-r_sq[k]) : PMAG_W'(r_sq[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_vv4  <= n_vv;
            r_id4  <= n_id;
            r_neg4 <= n_neg;
            r_mag4 <= n_mag;
            r_e2_4 <= r_e2_3;
            r_om4  <= UNIT2 - r_e2_3;
            r_q4   <= r_q3;
        end
    end

    // Dividends with the half-divisor rounding term folded in.
    always_comb begin
        mid.neg   = r_neg4;
        mid.vv    = r_vv4;
        mid.e2    = r_e2_4;
        mid.om    = r_om4;
        mid.ident = r_id4;
        for (int k = 0; k < NAX; k++) begin
            mid.q[k] = r_q4[k];
        end
        for (int k = 0; k < NRAT; k++) begin
            mid.num[k] = {r_mag4[k], {(2 * FB){1'b0}}} + NUM_W'(r_vv4 >> 1);
        end
    end

    // Two-entry queue between front and back.
    assign mq_push  = fen && r_v4;
    assign n_mq_cnt = r_mq_cnt + {1'b0, mq_push} - {1'b0, i_mq_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mq_wp  <= 1'b0;
            r_mq_rp  <= 1'b0;
            r_mq_cnt <= '0;
        end else begin
            if (mq_push) r_mq_wp <= !r_mq_wp;
            if (i_mq_pop) r_mq_rp <= !r_mq_rp;
            r_mq_cnt <= n_mq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mq_push) r_mq[r_mq_wp] <= mid;
    end

    assign o_mq_valid = (r_mq_cnt != '0);
    assign o_mq_item  = r_mq[r_mq_rp];

endmodule

FILE: sv/vvr_div.sv
module vvr_div
    import vvr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [VV_W-1:0]  i_den,
    output logic [QUO_W-1:0] o_quo
);

    // One quotient bit per stage, restoring long division.
    logic [VV_W-1:0]  r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [NUM_W-1:0] r_num [QUO_W];
    logic [VV_W-1:0]  r_den [QUO_W];

    logic [VV_W-1:0]  p_rem [QUO_W];
    logic [QUO_W-1:0] p_quo [QUO_W];
    logic [NUM_W-1:0] p_num [QUO_W];
    logic [VV_W-1:0]  p_den [QUO_W];

    logic [VV_W:0]    trial [QUO_W];
    logic             ge    [QUO_W];
    logic [VV_W-1:0]  n_rem [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];

    // Stage inputs: the first stage sees the new operands.
    always_comb begin
        p_rem[0] = VV_W'(i_num[NUM_W-1:QUO_W]);
        p_quo[0] = '0;
        p_num[0] = i_num;
        p_den[0] = i_den;
        for (int k = 1; k < QUO_W; k++) begin
            p_rem[k] = r_rem[k-1];
            p_quo[k] = r_quo[k-1];
            p_num[k] = r_num[k-1];
            p_den[k] = r_den[k-1];
        end
    end

    // Compare and subtract in every stage.
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            trial[k] = {p_rem[k], p_num[k][QUO_W-1-k]};
            ge[k]    = (trial[k] >= {1'b0, p_den[k]});
            n_rem[k] = ge[k] ? VV_W'(trial[k] - {1'b0, p_den[k]}) : VV_W'(trial[k]);
            n_quo[k] = {p_quo[k][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_num <= p_num;
            r_den <= p_den;
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

FILE: sv/vvr_back.sv
`include "vector_to_vector_rotation_macros.svh"

module vvr_back
    import vvr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_mq_valid,
    input  t_mid_item i_mq_item,
    output logic      o_mq_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    localparam logic [1:0] OQ_FULL = 2'd2;
    localparam logic [1:0] OQ_ONE  = 2'd1;
    localparam logic signed [M_W-1:0] RND_OUT = M_W'(1) << (OUT_SH - 1);
    localparam logic signed [M_W-1:0] SAT_HI  = M_W'(2 ** (CW - 1) - 1);
    localparam logic signed [M_W-1:0] SAT_LO  = -SAT_HI - M_W'(1);
    localparam logic signed [CW-1:0]  ONE_OUT = CW'(2 ** FB);

    function automatic logic signed [CW-1:0] round_sat(input logic signed [M_W-1:0] m);
        logic signed [M_W-1:0] r;
        r = (m + RND_OUT) >>> OUT_SH;
        if (r > SAT_HI) begin
            return CW'(SAT_HI);
        end else if (r < SAT_LO) begin
            return CW'(SAT_LO);
        end
        return CW'(r);
    endfunction

    logic ben;
    logic [QUO_W-1:0] quo [NRAT];

    logic [QUO_W-1:0] r_sv;
    t_side            r_side [QUO_W];
    t_side            side_in;

    logic                  r_vm, r_vs;
    logic signed [M_W-1:0] r_t [NRAT];
    t_side                 r_side_m, r_side_s;
    logic signed [R_W-1:0] rv [NRAT];
    logic signed [M_W-1:0] n_t [NRAT];
    logic signed [M_W-1:0] ediag;
    logic signed [M_W-1:0] qsc [NAX];
    logic signed [M_W-1:0] n_m [9];
    logic signed [M_W-1:0] r_m [9];
    logic signed [CW-1:0]  rs [9];

    t_out_item  oq_wdata;
    t_out_item  r_oq [2];
    logic       r_oq_wp, r_oq_rp;
    logic [1:0] r_oq_cnt;
    logic       oq_push, oq_pop;

    // The back advances together while the result queue has room.
    assign ben      = (r_oq_cnt != OQ_FULL);
    assign o_mq_pop = ben && i_mq_valid;

    // Six pipelined dividers, one for each distinct ratio.
    for (genvar g = 0; g < NRAT; g++) begin : g_div
        vvr_div u_div (
            .i_clk (i_clk),
            .i_en  (ben),
            .i_num (i_mq_item.num[g]),
            .i_den (i_mq_item.vv),
            .o_quo (quo[g])
        );
    end

    always_comb begin
        side_in.neg   = i_mq_item.neg;
        side_in.e2    = i_mq_item.e2;
        side_in.om    = i_mq_item.om;
        side_in.q     = i_mq_item.q;
        side_in.ident = i_mq_item.ident;
    end

    // Side data and valid bits that keep pace with the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (ben) begin
            r_sv <= {r_sv[QUO_W-2:0], i_mq_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_side[0] <= side_in;
            for (int k = 1; k < QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Multiply stage: signed ratio times one minus the dot product.
    always_comb begin
        for (int k = 0; k < NRAT; k++) begin
            rv[k]  = r_side[QUO_W-1].neg[k] ? -$signed({1'b0, quo[k]})
                                             : $signed({1'b0, quo[k]});
            n_t[k] = r_side[QUO_W-1].om * rv[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vs <= 1'b0;
        end else if (ben) begin
            r_vm <= r_sv[QUO_W-1];
            r_vs <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_t      <= n_t;
            r_side_m <= r_side[QUO_W-1];
            r_m      <= n_m;
            r_side_s <= r_side_m;
        end
    end

    // Sum stage: ratio terms plus the scaled dot product (diagonal) or skew terms.
    always_comb begin
        ediag = M_W'(r_side_m.e2) <<< (2 * FB);
        for (int k = 0; k < NAX; k++) begin
            qsc[k] = M_W'($signed(r_side_m.q[k])) <<< (3 * FB);
        end
        n_m[0] = ediag + r_t[RAT_XX];
        n_m[1] = r_t[RAT_XY] - qsc[AX_Z];
        n_m[2] = r_t[RAT_XZ] + qsc[AX_Y];
        n_m[3] = r_t[RAT_XY] + qsc[AX_Z];
        n_m[4] = ediag + r_t[RAT_YY];
        n_m[5] = r_t[RAT_YZ] - qsc[AX_X];
        n_m[6] = r_t[RAT_XZ] - qsc[AX_Y];
        n_m[7] = r_t[RAT_YZ] + qsc[AX_X];
        n_m[8] = ediag + r_t[RAT_ZZ];
    end

    // Rounding, saturation and the identity override.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            rs[k] = round_sat(r_m[k]);
        end
        if (r_side_s.ident) begin
            oq_wdata.rot_00 = ONE_OUT;
            oq_wdata.rot_01 = '0;
            oq_wdata.rot_02 = '0;
            oq_wdata.rot_10 = '0;
            oq_wdata.rot_11 = ONE_OUT;
            oq_wdata.rot_12 = '0;
            oq_wdata.rot_20 = '0;
            oq_wdata.rot_21 = '0;
            oq_wdata.rot_22 = ONE_OUT;
        end else begin
            oq_wdata.rot_00 = rs[0];
            oq_wdata.rot_01 = rs[1];
            oq_wdata.rot_02 = rs[2];
            oq_wdata.rot_10 = rs[3];
            oq_wdata.rot_11 = rs[4];
            oq_wdata.rot_12 = rs[5];
            oq_wdata.rot_20 = rs[6];
            oq_wdata.rot_21 = rs[7];
            oq_wdata.rot_22 = rs[8];
        end
        oq_wdata.identity_used = r_side_s.ident;
    end

    // Two-entry result queue.
    assign oq_push = ben && r_vs;
    assign oq_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) r_oq_wp <= !r_oq_wp;
            if (oq_pop) r_oq_rp <= !r_oq_rp;
            r_oq_cnt <= r_oq_cnt + {1'b0, oq_push} - {1'b0, oq_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) r_oq[r_oq_wp] <= oq_wdata;
    end

    assign o_empty = (r_oq_cnt == '0);
    assign o_item  = r_oq[r_oq_rp];

    `VVR_ASSERT_IMPLIES(a_oq_no_overflow, i_clk, i_rst_n, oq_push, r_oq_cnt != OQ_FULL)
    `VVR_ASSERT_NEXT(a_oq_count_up, i_clk, i_rst_n, oq_push && !oq_pop, r_oq_cnt == $past(r_oq_cnt) + OQ_ONE)
    `VVR_ASSERT_IMPLIES(a_ident_shape, i_clk, i_rst_n, oq_push && oq_wdata.identity_used, oq_wdata.rot_11 == ONE_OUT && oq_wdata.rot_12 == '0)
    `VVR_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !ben, r_vs == $past(r_vs))

endmodule

FILE: sv/vector_to_vector_rotation.sv
// Rotation matrix that turns a source 3-vector onto a target 3-vector.
// Input channel: a beat of six signed Q2.14 components enters when push is
// high and full is low. Result channel: while empty is low the oldest
// matrix sits on o_result; it leaves when pop is high. Each beat in gives
// exactly one beat out, in order.
// Configuration: i_cfg_we writes i_cfg_data into the squared cross-length
// threshold on the same edge; below it, or at zero cross length, the identity
// comes back with identity_used set. Reset value of the threshold is 1.
// Throughput: one beat per cycle sustained while pop keeps up. A beat
// passes through one register each for four front stages, the middle
// queue, 29 divider stages (one quotient bit each) and the multiply, sum
// and result queue stages before it shows on the outputs.
// When the receiver stops popping, the result queue fills, the back
// pipeline freezes, the middle queue fills and full rises; nothing is lost.
// Reset empties both queues and all pipeline valid bits and restores the
// threshold.
module vector_to_vector_rotation
    import vvr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_source_target,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_result,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_min_cross_sq;
    t_mq_ctl          mq_ctl;
    t_mid_item        mq_item;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cross_sq <= MIN_CROSS_RESET;
        end else if (i_cfg_we) begin
            r_min_cross_sq <= i_cfg_data;
        end
    end

    vvr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_item         (i_source_target),
        .i_min_cross_sq (r_min_cross_sq),
        .i_mq_pop       (mq_ctl.pop),
        .o_mq_valid     (mq_ctl.valid),
        .o_mq_item      (mq_item)
    );

    vvr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mq_valid (mq_ctl.valid),
        .i_mq_item  (mq_item),
        .o_mq_pop   (mq_ctl.pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_item     (o_result)
    );

endmodule

FILE: test/tb_vector_to_vector_rotation.sv
module tb_vector_to_vector_rotation
    import vvr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT    = 37;
    localparam int CYCLE_LIMIT = 400000;

    // Predicts the rotation matrix for one vector pair and holds the expected beats.
    class rotation_scoreboard;
        t_out_item       pending_q[$];
        logic [CFG_W-1:0] threshold;
        int              n_errors;

        function new();
            threshold = MIN_CROSS_RESET;
            n_errors  = 0;
        endfunction

        // x / 2^s, rounded half up.
        function automatic longint round_sh(longint x, int s);
            return (x + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        // Signed ratio a*b/vv with 2F fraction bits, rounded half away from zero.
        function automatic longint cross_ratio(longint a, longint b, longint vv);
            longint p;
            longint mag;
            longint q;
            p   = a * b;
            mag = (p < 0) ? -p : p;
            q   = ((mag <<< (2 * FB)) + (vv >>> 1)) / vv;
            return (p < 0) ? -q : q;
        endfunction

        function automatic logic signed [CW-1:0] clamp(longint x);
            longint r;
            r = round_sh(x, OUT_SH);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[CW-1:0];
        endfunction

        function void note_pair(t_in_item it);
            longint sx, sy, sz, tx, ty, tz, e2, qx, qy, qz, vv, om, ed, sc;
            longint t01, t02, t12;
            t_out_item r;
            sx = it.source_x; sy = it.source_y; sz = it.source_z;
            tx = it.target_x; ty = it.target_y; tz = it.target_z;
            e2 = sx * tx + sy * ty + sz * tz;
            qx = round_sh(sy * tz - sz * ty, FB);
            qy = round_sh(sz * tx - sx * tz, FB);
            qz = round_sh(sx * ty - sy * tx, FB);
            vv = qx * qx + qy * qy + qz * qz;
            if (vv == 0 || vv < longint'(threshold)) begin
                r = '0;
                r.rot_00 = 16'sd16384;
                r.rot_11 = 16'sd16384;
                r.rot_22 = 16'sd16384;
                r.identity_used = 1'b1;
            end else begin
                om  = (longint'(1) <<< (2 * FB)) - e2;
                ed  = e2 <<< (2 * FB);
                sc  = longint'(1) <<< (3 * FB);
                t01 = om * cross_ratio(qx, qy, vv);
                t02 = om * cross_ratio(qx, qz, vv);
                t12 = om * cross_ratio(qy, qz, vv);
                r.rot_00 = clamp(ed + om * cross_ratio(qx, qx, vv));
                r.rot_01 = clamp(t01 - qz * sc);
                r.rot_02 = clamp(t02 + qy * sc);
                r.rot_10 = clamp(t01 + qz * sc);
                r.rot_11 = clamp(ed + om * cross_ratio(qy, qy, vv));
                r.rot_12 = clamp(t12 - qx * sc);
                r.rot_20 = clamp(t02 - qy * sc);
                r.rot_21 = clamp(t12 + qx * sc);
                r.rot_22 = clamp(ed + om * cross_ratio(qz, qz, vv));
                r.identity_used = 1'b0;
            end
            pending_q.push_back(r);
        endfunction

        function void check_matrix(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                return;
            end
            want = pending_q.pop_front();
            if (got.rot_00 !== want.rot_00) report("rot_00", want.rot_00, got.rot_00);
            if (got.rot_01 !== want.rot_01) report("rot_01", want.rot_01, got.rot_01);
            if (got.rot_02 !== want.rot_02) report("rot_02", want.rot_02, got.rot_02);
            if (got.rot_10 !== want.rot_10) report("rot_10", want.rot_10, got.rot_10);
            if (got.rot_11 !== want.rot_11) report("rot_11", want.rot_11, got.rot_11);
            if (got.rot_12 !== want.rot_12) report("rot_12", want.rot_12, got.rot_12);
            if (got.rot_20 !== want.rot_20) report("rot_20", want.rot_20, got.rot_20);
            if (got.rot_21 !== want.rot_21) report("rot_21", want.rot_21, got.rot_21);
            if (got.rot_22 !== want.rot_22) report("rot_22", want.rot_22, got.rot_22);
            if (got.identity_used !== want.identity_used)
                report("identity_used", want.identity_used, got.identity_used);
        endfunction

        function void report(string field, longint want, longint got);
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    t_in_item         i_source_target = '0;
    logic             empty;
    logic             pop = 1'b0;
    t_out_item        o_result;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    rotation_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_recv = 1'b0;
    longint cycle_count = 0;

    vector_to_vector_rotation DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_source_target(i_source_target),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_vector_to_vector_rotation: errors");
            $finish;
        end
    end

    // Result side: check each accepted beat, pop with random stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_matrix(o_result);
        pop <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one pair until the block takes it; push stays up for a following pair.
    task automatic send_pair(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_source_target <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_pair(it);
    endtask

    // Waits until all results are back, then lets the pipeline settle.
    task automatic drain();
        push <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.threshold = value;
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd16384;
            3: return -16'sd16384;
            4: return '0;
            default: return $signed(16'($urandom_range(32767) - 16384)) + $signed(16'($urandom_range(1)));
        endcase
    endfunction

    // Random vector pair, mostly with components in [-1, 1]; some are nearly parallel or antiparallel.
    function automatic t_in_item rand_pair();
        t_in_item it;
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            it = {$urandom(), $urandom(), $urandom()};
        end else begin
            it.source_x = $signed(16'($urandom_range(32768))) - 16'sd16384;
            it.source_y = $signed(16'($urandom_range(32768))) - 16'sd16384;
            it.source_z = $signed(16'($urandom_range(32768))) - 16'sd16384;
            if (kind == 1) begin
                it.target_x = it.source_x + $signed(16'($urandom_range(8))) - 16'sd4;
                it.target_y = it.source_y + $signed(16'($urandom_range(8))) - 16'sd4;
                it.target_z = it.source_z;
            end else if (kind == 2) begin
                it.target_x = -it.source_x;
                it.target_y = -it.source_y + $signed(16'($urandom_range(4))) - 16'sd2;
                it.target_z = -it.source_z;
            end else if (kind == 3) begin
                it.target_x = rand_comp();
                it.target_y = rand_comp();
                it.target_z = rand_comp();
            end else begin
                it.target_x = $signed(16'($urandom_range(32768))) - 16'sd16384;
                it.target_y = $signed(16'($urandom_range(32768))) - 16'sd16384;
                it.target_z = $signed(16'($urandom_range(32768))) - 16'sd16384;
            end
        end
        return it;
    endfunction

    // Directed pairs: axes, extremes, parallel, antiparallel, zero vectors.
    task automatic send_directed();
        t_in_item list [$];
        list.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        list.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384});
        list.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0});
        list.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        list.push_back({16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0});
        list.push_back({96'h0});
        list.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        list.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        list.push_back({16'sh8000, 16'sh0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0});
        list.push_back({16'sd16384, 16'sd1, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        list.push_back({16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585});
        list.push_back({96'hffff_ffff_ffff_ffff_ffff_ffff});
        foreach (list[i]) send_pair(list[i]);
    endtask

    task automatic send_random(int count);
        repeat (count) send_pair(rand_pair());
    endtask

    // Holds the receiver off long enough for the block to back up.
    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_recv = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_recv = 1'b0;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        drain();
        write_threshold(31'd0);
        send_directed();
        send_random(150);
        drain();

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 20;
        recv_idle_pct = 61;
        write_threshold(31'd1);
        send_random(350);
        drain();

        // Pause with the pipeline empty, then swap the idling.
        write_threshold(31'h4000_0000);
        send_idle_pct = 61;
        recv_idle_pct = 20;
        send_random(150);
        drain();
        write_threshold(31'h7fff_ffff);
        send_random(50);
        drain();
        write_threshold(31'd5000);
        send_random(150);
        drain();

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(31'd1 << 20);
        send_random(300);
        drain();

        if (board.n_errors == 0)
            $display("tb_vector_to_vector_rotation: clean");
        else
            $display("tb_vector_to_vector_rotation: errors");
        $finish;
    end
endmodule
